### hw/rtl/n2a_pkg.sv
package n2a_pkg;

   localparam logic [1:0] CMD_DEC   = 2'd0;
   localparam logic [1:0] CMD_HEXLO = 2'd1;
   localparam logic [1:0] CMD_HEXUP = 2'd2;
   localparam logic [1:0] CMD_RAW   = 2'd3;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned DEC_DIGS = 10;
   localparam int unsigned BCD_W    = DEC_DIGS * 4;
   localparam int unsigned CNT_W    = 4;

   localparam logic [CNT_W-1:0] HEX_DIGS = 4'd8;
   localparam logic [7:0]       CH_LF    = 8'h0A;
   localparam logic [7:0]       CH_CR    = 8'h0D;
   localparam logic [3:0]       NIB_MASK = 4'h0F;

   typedef struct packed {
      logic [1:0]         command;
      logic [VALUE_W-1:0] value;
      logic [3:0]         hex_width;
   } req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_EMIT,
      ST_RAW,
      ST_CR
   } state_type;

   function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
      logic [7:0] ch;
      begin
         if (nib < 4'd10) begin
            ch = 8'h30 + {4'h0, nib};
         end else if (upper) begin
            ch = 8'h41 + {4'h0, nib - 4'd10};
         end else begin
            ch = 8'h61 + {4'h0, nib - 4'd10};
         end
         return ch;
      end
   endfunction

endpackage

### hw/rtl/number_to_ascii_formatter.sv
// Sequence, from the accepting edge to the edge that takes the last character: decimal runs
// the 32-step BCD conversion, then leading-zero skips and digits, leaving the skip state,
// and the output register; hex the same steps without the conversion; raw the byte, then a CR after a line feed.
// Throughput: busy drops as the last character is issued, so the next item may be accepted
// at the edge that takes that character; the receiver cannot stall.
// Synchronous active-high reset returns the sequencer to idle with no result pending.
module number_to_ascii_formatter (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  n2a_pkg::req_type req_data,
   output logic             rsp_strobe,
   output n2a_pkg::rsp_type rsp_data
);
   import n2a_pkg::*;

   state_type        state_ff, state_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [BCD_W-1:0] sr_ff, sr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] target_ff, target_in;
   logic             strobe_ff, strobe_in;
   rsp_type          rsp_ff, rsp_in;

   logic             dab_load;
   logic             dab_done;
   logic [BCD_W-1:0] dab_bcd;
   logic [3:0]       top_nib;
   logic [7:0]       raw_ch;
   logic             skip;
   logic [CNT_W-1:0] width_eff;

   n2a_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .load  (dab_load),
      .value (req_data.value),
      .done  (dab_done),
      .bcd   (dab_bcd)
   );

   assign top_nib = sr_ff[BCD_W-1 -: 4] & NIB_MASK;
   assign raw_ch  = sr_ff[15:8];
   assign width_eff = (req_data.hex_width == 4'd0 || req_data.hex_width > HEX_DIGS) ?
                      HEX_DIGS : req_data.hex_width;

   always_comb begin
      if (cmd_ff == CMD_DEC) begin
         skip = (cnt_ff > 4'd1) && (top_nib == 4'd0);
      end else begin
         skip = cnt_ff > target_ff;
      end
   end

   assign dab_load = (state_ff == ST_IDLE) && start && (req_data.command == CMD_DEC);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.command)
                  CMD_DEC:   state_in = ST_CONV;
                  CMD_RAW:   state_in = ST_RAW;
                  default:   state_in = ST_SKIP;
               endcase
            end
         end
         ST_CONV: begin
            if (dab_done) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (!skip) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cnt_ff == 4'd1) begin
               state_in = ST_IDLE;
            end
         end
         ST_RAW: begin
            state_in = (raw_ch == CH_LF) ? ST_CR : ST_IDLE;
         end
         ST_CR:   state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_in    = cmd_ff;
      sr_in     = sr_ff;
      cnt_in    = cnt_ff;
      target_in = target_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in    = req_data.command;
               sr_in     = {req_data.value, 8'h00};
               cnt_in    = HEX_DIGS;
               target_in = width_eff;
            end
         end
         ST_CONV: begin
            if (dab_done) begin
               sr_in     = dab_bcd;
               cnt_in    = CNT_W'(DEC_DIGS);
               target_in = 4'd1;
            end
         end
         ST_SKIP: begin
            if (skip) begin
               sr_in  = {sr_ff[BCD_W-5:0], 4'h0};
               cnt_in = cnt_ff - 4'd1;
            end
         end
         ST_EMIT: begin
            strobe_in        = 1'b1;
            rsp_in.character = digit_char(top_nib, cmd_ff == CMD_HEXUP);
            rsp_in.last      = cnt_ff == 4'd1;
            sr_in            = {sr_ff[BCD_W-5:0], 4'h0};
            cnt_in           = cnt_ff - 4'd1;
         end
         ST_RAW: begin
            strobe_in        = 1'b1;
            rsp_in.character = raw_ch;
            rsp_in.last      = raw_ch != CH_LF;
         end
         ST_CR: begin
            strobe_in        = 1'b1;
            rsp_in.character = CH_CR;
            rsp_in.last      = 1'b1;
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      cmd_ff    <= cmd_in;
      sr_ff     <= sr_in;
      cnt_ff    <= cnt_in;
      target_ff <= target_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### hw/rtl/n2a_dabble.sv
module n2a_dabble (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic [n2a_pkg::VALUE_W-1:0] value,
   output logic                      done,
   output logic [n2a_pkg::BCD_W-1:0]   bcd
);
   import n2a_pkg::*;

   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [VALUE_W-1:0]   bin_ff, bin_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [BCD_W-1:0]     adj;

   // add-3 on every digit of 5 or more, then one shift
   always_comb begin
      for (int i = 0; i < DEC_DIGS; i++) begin
         if (bcd_ff[i*4 +: 4] > 4'd4) begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      if (load) begin
         active_in = 1'b1;
         cnt_in    = '0;
         bin_in    = value;
         bcd_in    = '0;
      end else if (active_ff) begin
         bcd_in = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule
